/* rtl/core/gpl_pkg.sv */
package gpl_pkg;

    // Grid shape and number format
    localparam int AXES       = 3;
    localparam int MAX_KNOTS  = 64;
    localparam int COORD_BITS = 32;

    // Field widths
    localparam int SLOT_W = 6;                      // knot slot / interval index
    localparam int CNT_W  = 7;                      // knot count register
    localparam int AXIS_W = 2;
    localparam int FLAT_W = 18;
    localparam int CFG_IDX_W = 2;
    localparam int TERM_W = 2 * SLOT_W + 1;         // iy + (ny-1)*iz
    localparam int PROD_W = SLOT_W + TERM_W + 1;    // ix + (nx-1)*term

    // Item opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOCATE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT_Z = 2'd2;

    localparam logic [CNT_W-1:0] KNOT_COUNT_RESET = 7'd2;

    // Top level to one axis lane
    typedef struct packed {
        logic                         start;
        logic signed [COORD_BITS-1:0] coord;
        logic [CNT_W-1:0]             count;
        logic                         load;
        logic [SLOT_W-1:0]            slot;
        logic [COORD_BITS-1:0]        value;
    } t_lane_cmd;

    // One axis lane back to the top level
    typedef struct packed {
        logic              done;
        logic              below;
        logic              above;
        logic [SLOT_W-1:0] interval;
        logic [SLOT_W-1:0] nint;
    } t_lane_res;

    // Lane results gathered for the merge stage (axis 0 in slot 0)
    typedef struct packed {
        logic [2:0][SLOT_W-1:0] iv;
        logic [2:0][SLOT_W-1:0] nint;
        logic                   outside;
    } t_merge_in;

endpackage

/* rtl/core/grid_point_locator.sv */
// Load item: the knot is written at the transfer edge, no result.
// Locate item: the result comes from the first- and last-knot reads, then P
// binary-search probes for the largest knot count in use (P <= 7 for 64 knots),
// then the merge stage. One locate in flight: the next item is taken once all
// lanes hand off to the merge; a stalled result with one queued holds it off.
// Reset (i_rst_n low, synchronous): control cleared, knot counts back to 2.
// Knot table contents are not reset; unwritten knots read as don't-care.
module grid_point_locator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic [gpl_pkg::AXIS_W-1:0]          i_axis,
    input  logic [gpl_pkg::SLOT_W-1:0]          i_knot_slot,
    input  logic signed [gpl_pkg::COORD_BITS-1:0] i_knot_value,
    input  logic signed [gpl_pkg::COORD_BITS-1:0] i_coord_x,
    input  logic signed [gpl_pkg::COORD_BITS-1:0] i_coord_y,
    input  logic signed [gpl_pkg::COORD_BITS-1:0] i_coord_z,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [gpl_pkg::FLAT_W-1:0]          o_element_flat,
    output logic [gpl_pkg::SLOT_W-1:0]          o_interval_x,
    output logic [gpl_pkg::SLOT_W-1:0]          o_interval_y,
    output logic [gpl_pkg::SLOT_W-1:0]          o_interval_z,
    output logic                                o_outside,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [gpl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gpl_pkg::CNT_W-1:0]           i_cfg_data
);
    import gpl_pkg::*;

    // Architecture:
    //   One lane per axis. Each lane owns that axis' knot memory (single read
    //   port, registered data) and walks: read first knot, read last knot,
    //   then one binary-search probe per cycle. Lanes run in parallel and may
    //   finish at different times; the controller waits for all of them.
    //   The merge stage builds the flat element index in two multiply stages
    //   and holds the result in an output register, so a new item can be
    //   taken while a finished result is still waiting for its transfer.

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                         r_state;
    logic [2:0][CNT_W-1:0]          r_knot_count;

    logic                           w_accept;
    logic                           w_locate;
    logic                           w_slot_ok;
    logic                           w_handoff;
    logic                           w_m_ready;
    logic [AXES-1:0]                w_done;
    logic [AXES-1:0]                w_out_flag;
    logic signed [2:0][COORD_BITS-1:0] w_coord;
    t_lane_cmd                      w_cmd [AXES];
    t_lane_res                      w_res [AXES];
    t_merge_in                      w_merge;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_locate   = w_accept && (i_op == OP_LOCATE);
    assign w_slot_ok  = CNT_W'(i_knot_slot) < CNT_W'(MAX_KNOTS);
    assign w_coord    = {i_coord_z, i_coord_y, i_coord_x};

    // handing off frees the lanes for the next locate
    assign w_handoff  = (r_state == S_RUN) && (&w_done) && w_m_ready;

    // configuration registers; writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= {3{KNOT_COUNT_RESET}};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KNOT_COUNT_X: r_knot_count[0] <= i_cfg_data;
                CFG_KNOT_COUNT_Y: r_knot_count[1] <= i_cfg_data;
                CFG_KNOT_COUNT_Z: r_knot_count[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (w_locate) r_state <= S_RUN;
                S_RUN:   if (w_handoff) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        // loads go straight into the addressed axis' memory
        assign w_cmd[a].start = w_locate;
        assign w_cmd[a].coord = w_coord[a];
        assign w_cmd[a].count = r_knot_count[a];
        assign w_cmd[a].load  = w_accept && (i_op == OP_LOAD) && w_slot_ok &&
                                (i_axis == AXIS_W'(a));
        assign w_cmd[a].slot  = i_knot_slot;
        assign w_cmd[a].value = i_knot_value;

        gpl_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[a]),
            .i_ack   (w_handoff),
            .o_res   (w_res[a])
        );

        assign w_done[a]     = w_res[a].done;
        assign w_out_flag[a] = w_res[a].below || w_res[a].above;
    end

    // unused axes: interval 0, one interval along that axis
    for (genvar a = 0; a < 3; a++) begin : g_gather
        if (a < AXES) begin : g_used
            assign w_merge.iv[a]   = w_res[a].interval;
            assign w_merge.nint[a] = w_res[a].nint;
        end else begin : g_unused
            assign w_merge.iv[a]   = '0;
            assign w_merge.nint[a] = SLOT_W'(1);
        end
    end
    assign w_merge.outside = |w_out_flag;

    gpl_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_handoff),
        .o_ready   (w_m_ready),
        .i_data    (w_merge),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_flat    (o_element_flat),
        .o_iv_x    (o_interval_x),
        .o_iv_y    (o_interval_y),
        .o_iv_z    (o_interval_z),
        .o_outside (o_outside)
    );

endmodule

/* rtl/core/gpl_lane.sv */
module gpl_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gpl_pkg::t_lane_cmd i_cmd,
    input  logic               i_ack,
    output gpl_pkg::t_lane_res o_res
);
    import gpl_pkg::*;

    typedef enum logic [2:0] {
        L_IDLE,
        L_LO,
        L_HI,
        L_SEARCH,
        L_DONE
    } t_phase;

    logic [COORD_BITS-1:0]        r_mem [MAX_KNOTS];
    logic [COORD_BITS-1:0]        r_rdata;
    logic [SLOT_W-1:0]            w_raddr;

    t_phase                       r_phase;
    logic signed [COORD_BITS-1:0] r_coord;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_lo;
    logic [CNT_W-1:0]             r_len;
    logic                         r_below;
    logic                         r_above;
    logic [SLOT_W-1:0]            r_interval;

    logic [CNT_W-1:0]             w_half;
    logic                         w_less;
    logic [CNT_W-1:0]             n_lo;
    logic [CNT_W-1:0]             n_len;
    logic [CNT_W-1:0]             w_j1;
    logic [CNT_W-1:0]             w_last;
    logic [CNT_W-1:0]             w_iv;
    logic [CNT_W-1:0]             w_count;

    // one search step: probe lo + len/2, move past it when knot < coord
    assign w_half = r_len >> 1;
    assign w_less = $signed(r_rdata) < r_coord;
    assign n_lo   = w_less ? (r_lo + w_half + CNT_W'(1)) : r_lo;
    assign n_len  = w_less ? (r_len - w_half - CNT_W'(1)) : w_half;

    // interval below the found knot, saturated to the last interval
    assign w_j1   = (n_lo == '0) ? '0 : (n_lo - CNT_W'(1));
    assign w_last = r_count - CNT_W'(2);
    assign w_iv   = (w_j1 > w_last) ? w_last : w_j1;

    // counts outside 2..MAX_KNOTS are pinned
    always_comb begin
        if (i_cmd.count < CNT_W'(2)) begin
            w_count = CNT_W'(2);
        end else if (i_cmd.count > CNT_W'(MAX_KNOTS)) begin
            w_count = CNT_W'(MAX_KNOTS);
        end else begin
            w_count = i_cmd.count;
        end
    end

    // read address for the data used in the next phase
    always_comb begin
        case (r_phase)
            L_IDLE:   w_raddr = '0;
            L_LO:     w_raddr = SLOT_W'(r_count - CNT_W'(1));
            L_HI:     w_raddr = SLOT_W'(r_count >> 1);
            L_SEARCH: w_raddr = SLOT_W'(n_lo + (n_len >> 1));
            default:  w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[i_cmd.slot] <= i_cmd.value;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= L_IDLE;
        end else begin
            case (r_phase)
                L_IDLE: begin
                    if (i_cmd.start) begin
                        r_coord <= i_cmd.coord;
                        r_count <= w_count;
                        r_phase <= L_LO;
                    end
                end
                L_LO: begin
                    r_below <= r_coord < $signed(r_rdata);
                    r_phase <= L_HI;
                end
                L_HI: begin
                    r_above <= r_coord > $signed(r_rdata);
                    r_lo    <= '0;
                    r_len   <= r_count;
                    r_phase <= L_SEARCH;
                end
                L_SEARCH: begin
                    r_lo  <= n_lo;
                    r_len <= n_len;
                    if (n_len == '0) begin
                        r_interval <= SLOT_W'(w_iv);
                        r_phase    <= L_DONE;
                    end
                end
                L_DONE: begin
                    if (i_ack) begin
                        r_phase <= L_IDLE;
                    end
                end
                default: r_phase <= L_IDLE;
            endcase
        end
    end

    assign o_res.done     = (r_phase == L_DONE);
    assign o_res.below    = r_below;
    assign o_res.above    = r_above;
    assign o_res.interval = r_interval;
    assign o_res.nint     = SLOT_W'(r_count - CNT_W'(1));

endmodule

/* rtl/core/gpl_merge.sv */
module gpl_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  gpl_pkg::t_merge_in          i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [gpl_pkg::FLAT_W-1:0]  o_flat,
    output logic [gpl_pkg::SLOT_W-1:0]  o_iv_x,
    output logic [gpl_pkg::SLOT_W-1:0]  o_iv_y,
    output logic [gpl_pkg::SLOT_W-1:0]  o_iv_z,
    output logic                        o_outside
);
    import gpl_pkg::*;

    logic              r_s1_valid;
    t_merge_in         r_s1;
    logic [TERM_W-1:0] r_s1_term;
    logic              r_out_valid;
    logic [FLAT_W-1:0] r_flat;
    logic [2:0][SLOT_W-1:0] r_iv;
    logic              r_outside;

    logic [TERM_W-1:0] w_term;
    logic [PROD_W-1:0] w_flat;
    logic              w_adv;

    // stage 1: iy + (ny-1)*iz ; stage 2: ix + (nx-1)*stage1
    assign w_term = TERM_W'(i_data.iv[1]) + TERM_W'(i_data.nint[1]) * TERM_W'(i_data.iv[2]);
    assign w_flat = PROD_W'(r_s1.iv[0]) + PROD_W'(r_s1.nint[0]) * PROD_W'(r_s1_term);

    assign o_ready = !r_s1_valid;
    assign w_adv   = r_s1_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_s1_valid <= 1'b1;
                r_s1       <= i_data;
                r_s1_term  <= w_term;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_flat      <= FLAT_W'(w_flat);
                r_iv        <= r_s1.iv;
                r_outside   <= r_s1.outside;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_flat    = r_flat;
    assign o_iv_x    = r_iv[0];
    assign o_iv_y    = r_iv[1];
    assign o_iv_z    = r_iv[2];
    assign o_outside = r_outside;

endmodule

/* rtl/core/gpl_checker.sv */
module gpl_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic                                i_op,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [gpl_pkg::FLAT_W-1:0]          o_element_flat,
    input  logic [gpl_pkg::SLOT_W-1:0]          o_interval_x,
    input  logic [gpl_pkg::SLOT_W-1:0]          o_interval_y,
    input  logic [gpl_pkg::SLOT_W-1:0]          o_interval_z
);
    import gpl_pkg::*;

    // a pending result is held until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_element_flat))
        else $error("result dropped or changed while stalled");

    // only one locate in flight: input closes right after a locate transfer
    a_one_locate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_LOCATE) |=> !o_in_ready)
        else $error("input still open after locate transfer");

    // intervals saturate at knot count minus two; checked against MAX_KNOTS minus two
    a_iv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_interval_x <= SLOT_W'(MAX_KNOTS - 2)) &&
                        (o_interval_y <= SLOT_W'(MAX_KNOTS - 2)) &&
                        (o_interval_z <= SLOT_W'(MAX_KNOTS - 2)))
        else $error("interval beyond last interval");

    // reset leaves no result behind
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind grid_point_locator gpl_checker u_gpl_checker (.*);
